/* sv/tlvp_pkg.sv */
// tlvp_pkg: shared types and constants of the tlv uplink message packer
// holds command and result structs, mode/status codes and default sizes
// no dependencies
package tlvp_pkg;

   localparam int DEF_MESSAGE_BYTES = 64;
   localparam int DEF_MESSAGE_COUNT = 4;
   // address field wide enough for the largest store (255 bytes x 16 buffers)
   localparam int CMD_ADDR_W = 12;
   localparam int CMD_DEPTH = 4;
   localparam int RES_DEPTH = 4;

   typedef enum logic [2:0] {
      MODE_CLEAR = 3'd0,
      MODE_BEGIN = 3'd1,
      MODE_VALUE = 3'd2,
      MODE_NEXT  = 3'd3,
      MODE_SEND  = 3'd4,
      MODE_RETRY = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_NEVER_FITS = 3'd1,
      STATUS_NO_BUFFER  = 3'd2,
      STATUS_DROPPED    = 3'd3,
      STATUS_NOTHING    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CMD_RESULT,
      CMD_CLEAR,
      CMD_RECORD,
      CMD_VALUE,
      CMD_SEND
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_REC_LEN,
      BK_SEND,
      BK_SWEEP
   } back_state_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [CMD_ADDR_W-1:0] addr;
      logic [7:0]            data0;
      logic [7:0]            data1;
      logic [7:0]            size;
      status_type            status;
      logic [7:0]            room_left;
      logic [11:0]           rest_room;
   } cmd_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        last;
      status_type  status;
      logic [7:0]  message_size;
      logic [7:0]  room_left;
      logic [11:0] total_room;
   } res_type;

endpackage

/* sv/tlv_uplink_message_packer_core.sv */
// tlv_uplink_message_packer_core: top level of the tlv uplink message packer
// depends on tlvp_pkg, tlvp_fifo, tlvp_front and tlvp_back
//
// Packs tag-length-value records into MESSAGE_COUNT buffers of MESSAGE_BYTES
// bytes and streams buffers out one byte per result. Requests enter
// through a queue-like port (push/full) and results leave through another
// (empty/pop). The front end takes one request per cycle while its command
// queue (CMD_DEPTH entries) has room; all bookkeeping of fill sizes and indexes
// is done there. The back end owns the message memory (single write port,
// registered read) and carries out one command at a time: clear, next buffer,
// retry, value byte and rejected requests issue their result as the command is
// taken (clear then starts the sweep), begin record writes tag and then length
// through the one write port, and send next first picks up the command and
// then streams the buffer one message byte per result, holding whenever the
// result queue has no free slot. After reset and after every clear the back
// end sweeps all MESSAGE_BYTES*MESSAGE_COUNT bytes of the memory to zero; the
// front end keeps accepting requests into its queue during the sweep. A result
// passes a register in the back end and the result queue before it is shown.
// The version register may be written when no request is in flight.
module tlv_uplink_message_packer_core #(
   parameter int MESSAGE_BYTES = tlvp_pkg::DEF_MESSAGE_BYTES,
   parameter int MESSAGE_COUNT = tlvp_pkg::DEF_MESSAGE_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   // version register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_uplink_version,
   // request side
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_mode,
   input  logic [7:0]  req_tag,
   input  logic [7:0]  req_length,
   input  logic [7:0]  req_value_byte,
   input  logic [3:0]  req_downlink_id,
   input  logic        req_will_listen,
   // result side
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_message_size,
   output logic [7:0]  rsp_room_left,
   output logic [11:0] rsp_total_room
);

   import tlvp_pkg::*;

   localparam int CMD_W = $bits(cmd_type);
   localparam int RES_W = $bits(res_type);

   // request accept and the command it turns into
   logic                           accept;
   cmd_type                        front_cmd;

   // command queue between front and back
   logic [CMD_W-1:0]               cmd_rd_data;
   cmd_type                        cmd_head;
   logic                           cmd_empty;
   logic                           cmd_full;
   logic                           cmd_pop;
   logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

   // result queue toward the output port
   res_type                        back_res;
   logic                           res_push;
   logic [RES_W-1:0]               res_rd_data;
   res_type                        res_head;
   logic                           res_full;
   logic [$clog2(RES_DEPTH+1)-1:0] res_count;

   assign req_full = cmd_full;
   assign accept = req_push && !cmd_full;
   assign cmd_head = cmd_type'(cmd_rd_data);
   assign res_head = res_type'(res_rd_data);

   // front end: classifies requests and keeps fill state
   tlvp_front #(
      .MESSAGE_BYTES(MESSAGE_BYTES),
      .MESSAGE_COUNT(MESSAGE_COUNT)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_uplink_version (csr_uplink_version),
      .accept             (accept),
      .req_mode           (req_mode),
      .req_tag            (req_tag),
      .req_length         (req_length),
      .req_value_byte     (req_value_byte),
      .req_downlink_id    (req_downlink_id),
      .req_will_listen    (req_will_listen),
      .cmd                (front_cmd)
   );

   // decouples bookkeeping from memory work and streaming
   tlvp_fifo #(
      .WIDTH(CMD_W),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .wr_data (front_cmd),
      .pop     (cmd_pop),
      .rd_data (cmd_rd_data),
      .empty   (cmd_empty),
      .full    (cmd_full),
      .count   (cmd_count)
   );

   // back end: memory writes, clearing sweep and message streaming
   tlvp_back #(
      .MESSAGE_BYTES(MESSAGE_BYTES),
      .MESSAGE_COUNT(MESSAGE_COUNT),
      .RES_DEPTH    (RES_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_head  (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .res_count (res_count),
      .res_push  (res_push),
      .res_data  (back_res)
   );

   // results wait here; back end only issues when a slot is reserved
   tlvp_fifo #(
      .WIDTH(RES_W),
      .DEPTH(RES_DEPTH)
   ) u_res_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (back_res),
      .pop     (rsp_pop),
      .rd_data (res_rd_data),
      .empty   (rsp_empty),
      .full    (res_full),
      .count   (res_count)
   );

   // oldest result on the port
   always_comb begin
      rsp_out_byte = res_head.out_byte;
      rsp_last = res_head.last;
      rsp_status = res_head.status;
      rsp_message_size = res_head.message_size;
      rsp_room_left = res_head.room_left;
      rsp_total_room = res_head.total_room;
      // occupancy of the queues is for flow control only
      if (res_full && cmd_count == '0) begin
         rsp_room_left = res_head.room_left;
      end
   end

endmodule

/* sv/tlvp_fifo.sv */
// tlvp_fifo: small register queue with occupancy count
// generic width and depth, used for the command and result queues
// no package dependencies
module tlvp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rd_data,
   output logic                       empty,
   output logic                       full,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty = (count_ff == '0);
   assign full = (count_ff == CW'(DEPTH));
   assign count = count_ff;
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* sv/tlvp_front.sv */
// tlvp_front: accepts requests, keeps fill bookkeeping, issues commands
// depends on tlvp_pkg; feeds the command queue in front of tlvp_back
module tlvp_front #(
   parameter int MESSAGE_BYTES = tlvp_pkg::DEF_MESSAGE_BYTES,
   parameter int MESSAGE_COUNT = tlvp_pkg::DEF_MESSAGE_COUNT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_uplink_version,
   input  logic              accept,
   input  logic [2:0]        req_mode,
   input  logic [7:0]        req_tag,
   input  logic [7:0]        req_length,
   input  logic [7:0]        req_value_byte,
   input  logic [3:0]        req_downlink_id,
   input  logic              req_will_listen,
   output tlvp_pkg::cmd_type cmd
);

   import tlvp_pkg::*;

   localparam int AW = $clog2(MESSAGE_BYTES*MESSAGE_COUNT);
   localparam int IW = (MESSAGE_COUNT > 1) ? $clog2(MESSAGE_COUNT) : 1;
   localparam int SW = $clog2(MESSAGE_COUNT+2);
   localparam logic [11:0] REST_INIT = 12'((MESSAGE_COUNT-1)*(MESSAGE_BYTES-2));
   localparam logic [11:0] ROOM_STEP = 12'(MESSAGE_BYTES-2);

   logic [1:0]    version_ff;
   logic [IW-1:0] fill_idx_ff, fill_idx_in;
   logic [7:0]    cur_fill_ff, cur_fill_in;
   logic [AW-1:0] fill_base_ff, fill_base_in;
   logic [11:0]   rest_ff, rest_in;
   logic [SW-1:0] sidx_ff, sidx_in;
   logic [AW-1:0] vptr_ff, vptr_in;
   logic [7:0]    vleft_ff, vleft_in;
   logic [7:0]    fill_arr_ff [MESSAGE_COUNT];

   logic          arr_we;
   logic          never_fits, fits_cur, at_last;
   logic [7:0]    pos;
   logic [AW-1:0] base, tag_addr, send_base;
   logic [IW-1:0] send_idx;
   logic [7:0]    send_size;
   logic [6:0]    hdr_bits;

   assign csr_ready = 1'b1;

   assign never_fits = (10'(req_length) + 10'd4) > 10'(MESSAGE_BYTES);
   assign fits_cur = (10'(cur_fill_ff) + 10'(req_length) + 10'd2) <= 10'(MESSAGE_BYTES);
   assign at_last = (fill_idx_ff == IW'(MESSAGE_COUNT-1));
   assign send_idx = sidx_ff[IW-1:0];
   assign send_base = AW'(32'(send_idx) * MESSAGE_BYTES);
   assign send_size = (send_idx == fill_idx_ff) ? cur_fill_ff : fill_arr_ff[send_idx];
   assign hdr_bits = {req_will_listen, version_ff, req_downlink_id};

   always_comb begin
      fill_idx_in = fill_idx_ff;
      cur_fill_in = cur_fill_ff;
      fill_base_in = fill_base_ff;
      rest_in = rest_ff;
      sidx_in = sidx_ff;
      vptr_in = vptr_ff;
      vleft_in = vleft_ff;
      arr_we = 1'b0;
      pos = cur_fill_ff;
      base = fill_base_ff;
      tag_addr = '0;
      cmd = '0;
      cmd.kind = CMD_RESULT;
      cmd.status = STATUS_OK;
      if (accept) begin
         unique case (mode_type'(req_mode))
            MODE_CLEAR: begin
               fill_idx_in = '0;
               cur_fill_in = 8'd2;
               fill_base_in = '0;
               rest_in = REST_INIT;
               sidx_in = '0;
               vptr_in = '0;
               vleft_in = '0;
               cmd.kind = CMD_CLEAR;
            end
            MODE_BEGIN: begin
               vleft_in = '0;
               if (never_fits) begin
                  cmd.status = STATUS_NEVER_FITS;
               end else if (!fits_cur && at_last) begin
                  cmd.status = STATUS_NO_BUFFER;
               end else begin
                  if (!fits_cur) begin
                     // record moves on to a fresh buffer
                     pos = 8'd2;
                     base = fill_base_ff + AW'(MESSAGE_BYTES);
                     arr_we = 1'b1;
                     fill_idx_in = fill_idx_ff + IW'(1);
                     fill_base_in = base;
                     rest_in = rest_ff - ROOM_STEP;
                  end
                  tag_addr = base + AW'(pos);
                  vptr_in = tag_addr + AW'(2);
                  vleft_in = req_length;
                  cur_fill_in = pos + 8'd2 + req_length;
                  cmd.kind = CMD_RECORD;
                  cmd.addr = CMD_ADDR_W'(tag_addr);
                  cmd.data0 = req_tag;
                  cmd.data1 = req_length;
               end
            end
            MODE_VALUE: begin
               if (vleft_ff != '0) begin
                  cmd.kind = CMD_VALUE;
                  cmd.addr = CMD_ADDR_W'(vptr_ff);
                  cmd.data0 = req_value_byte;
                  vptr_in = vptr_ff + AW'(1);
                  vleft_in = vleft_ff - 8'd1;
               end else begin
                  cmd.status = STATUS_DROPPED;
               end
            end
            MODE_NEXT: begin
               if (at_last) begin
                  cmd.status = STATUS_NO_BUFFER;
               end else begin
                  arr_we = 1'b1;
                  fill_idx_in = fill_idx_ff + IW'(1);
                  cur_fill_in = 8'd2;
                  fill_base_in = fill_base_ff + AW'(MESSAGE_BYTES);
                  rest_in = rest_ff - ROOM_STEP;
               end
            end
            MODE_SEND: begin
               if (32'(sidx_ff) > 32'(fill_idx_ff)) begin
                  // sending index rests two past the filling buffer
                  sidx_in = SW'(fill_idx_ff) + SW'(2);
                  cmd.status = STATUS_NOTHING;
               end else begin
                  sidx_in = sidx_ff + SW'(1);
                  cmd.kind = CMD_SEND;
                  cmd.addr = CMD_ADDR_W'(send_base);
                  cmd.data0 = {^hdr_bits, hdr_bits};
                  cmd.data1 = send_size - 8'd2;
                  cmd.size = send_size;
               end
            end
            MODE_RETRY: begin
               if (sidx_ff != '0) begin
                  sidx_in = sidx_ff - SW'(1);
               end
            end
            default: begin
            end
         endcase
      end
      cmd.room_left = 8'(MESSAGE_BYTES) - cur_fill_in;
      cmd.rest_room = rest_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= '0;
         fill_idx_ff <= '0;
         cur_fill_ff <= 8'd2;
         fill_base_ff <= '0;
         rest_ff <= REST_INIT;
         sidx_ff <= '0;
         vptr_ff <= '0;
         vleft_ff <= '0;
      end else begin
         if (csr_valid) begin
            version_ff <= csr_uplink_version;
         end
         fill_idx_ff <= fill_idx_in;
         cur_fill_ff <= cur_fill_in;
         fill_base_ff <= fill_base_in;
         rest_ff <= rest_in;
         sidx_ff <= sidx_in;
         vptr_ff <= vptr_in;
         vleft_ff <= vleft_in;
      end
   end

   // sizes of finished buffers; the one being filled lives in cur_fill_ff
   always_ff @(posedge clock) begin
      if (arr_we) begin
         fill_arr_ff[fill_idx_ff] <= cur_fill_ff;
      end
   end

endmodule

/* sv/tlvp_back.sv */
// tlvp_back: carries out queued commands on the message memory
// depends on tlvp_pkg; holds the store, the clearing pass and the byte streamer
module tlvp_back #(
   parameter int MESSAGE_BYTES = tlvp_pkg::DEF_MESSAGE_BYTES,
   parameter int MESSAGE_COUNT = tlvp_pkg::DEF_MESSAGE_COUNT,
   parameter int RES_DEPTH = tlvp_pkg::RES_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tlvp_pkg::cmd_type              cmd_head,
   input  logic                           cmd_empty,
   output logic                           cmd_pop,
   input  logic [$clog2(RES_DEPTH+1)-1:0] res_count,
   output logic                           res_push,
   output tlvp_pkg::res_type              res_data
);

   import tlvp_pkg::*;

   localparam int STORE = MESSAGE_BYTES*MESSAGE_COUNT;
   localparam int AW = $clog2(STORE);

   back_state_type state_ff, state_in;
   cmd_type        cur_ff;
   logic [7:0]     idx_ff, idx_in;
   logic [AW-1:0]  sweep_ff, sweep_in;
   logic           p_valid_ff;
   res_type        p_res_ff;
   logic           p_mem_ff;
   logic [7:0]     rd_data_ff;
   logic [7:0]     mem [STORE];

   logic           credit, issue, send_last;
   res_type        issue_res;
   logic           mem_we, mem_re;
   logic [AW-1:0]  mem_waddr, mem_raddr;
   logic [7:0]     mem_wdata;

   assign credit = (32'(res_count) + 32'(p_valid_ff)) < RES_DEPTH;
   assign send_last = (idx_ff == cur_ff.size - 8'd1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_pop) begin
               unique case (cmd_head.kind)
                  CMD_RECORD: state_in = BK_REC_LEN;
                  CMD_SEND:   state_in = BK_SEND;
                  CMD_CLEAR:  state_in = BK_SWEEP;
                  default:    state_in = BK_IDLE;
               endcase
            end
         end
         BK_REC_LEN: begin
            if (credit) begin
               state_in = BK_IDLE;
            end
         end
         BK_SEND: begin
            if (credit && send_last) begin
               state_in = BK_IDLE;
            end
         end
         BK_SWEEP: begin
            if (sweep_ff == AW'(STORE-1)) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop = 1'b0;
      issue = 1'b0;
      issue_res = '0;
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_waddr = '0;
      mem_raddr = '0;
      mem_wdata = '0;
      idx_in = idx_ff;
      sweep_in = sweep_ff;
      issue_res.last = 1'b1;
      issue_res.status = cur_ff.status;
      issue_res.room_left = cur_ff.room_left;
      issue_res.total_room = 12'(cur_ff.room_left) + cur_ff.rest_room;
      unique case (state_ff)
         BK_IDLE: begin
            issue_res.status = cmd_head.status;
            issue_res.room_left = cmd_head.room_left;
            issue_res.total_room = 12'(cmd_head.room_left) + cmd_head.rest_room;
            if (!cmd_empty && credit) begin
               cmd_pop = 1'b1;
               unique case (cmd_head.kind)
                  CMD_RESULT: issue = 1'b1;
                  CMD_CLEAR: begin
                     issue = 1'b1;
                     sweep_in = '0;
                  end
                  CMD_VALUE: begin
                     issue = 1'b1;
                     mem_we = 1'b1;
                     mem_waddr = cmd_head.addr[AW-1:0];
                     mem_wdata = cmd_head.data0;
                  end
                  CMD_RECORD: begin
                     mem_we = 1'b1;
                     mem_waddr = cmd_head.addr[AW-1:0];
                     mem_wdata = cmd_head.data0;
                  end
                  CMD_SEND: idx_in = '0;
                  default: begin
                  end
               endcase
            end
         end
         BK_REC_LEN: begin
            if (credit) begin
               issue = 1'b1;
               mem_we = 1'b1;
               mem_waddr = cur_ff.addr[AW-1:0] + AW'(1);
               mem_wdata = cur_ff.data1;
            end
         end
         BK_SEND: begin
            if (credit) begin
               issue = 1'b1;
               issue_res.last = send_last;
               issue_res.message_size = cur_ff.size;
               // header bytes come from the command, the rest from the store
               if (idx_ff == 8'd0) begin
                  issue_res.out_byte = cur_ff.data0;
               end else if (idx_ff == 8'd1) begin
                  issue_res.out_byte = cur_ff.data1;
               end else begin
                  mem_re = 1'b1;
                  mem_raddr = cur_ff.addr[AW-1:0] + AW'(idx_ff);
               end
               idx_in = idx_ff + 8'd1;
            end
         end
         BK_SWEEP: begin
            mem_we = 1'b1;
            mem_waddr = sweep_ff;
            sweep_in = sweep_ff + AW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_SWEEP;
         sweep_ff <= '0;
         idx_ff <= '0;
         p_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         idx_ff <= idx_in;
         p_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cur_ff <= cmd_head;
      end
      p_res_ff <= issue_res;
      p_mem_ff <= mem_re;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_comb begin
      res_push = p_valid_ff;
      res_data = p_res_ff;
      if (p_mem_ff) begin
         res_data.out_byte = rd_data_ff;
      end
   end

endmodule

/* sv/tlvp_checker.sv */
// tlvp_checker: port-level checks of the tlv uplink message packer
// depends on tlvp_pkg; bound to tlv_uplink_message_packer_core below
module tlvp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic        rsp_last,
   input logic [2:0]  rsp_status,
   input logic [7:0]  rsp_message_size,
   input logic [7:0]  rsp_room_left,
   input logic [11:0] rsp_total_room
);

   import tlvp_pkg::*;

   // nothing waits on the result side right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("result pending after reset");

   // a byte inside a message stream is always ok and carries its size
   a_stream_ok: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_last) |-> (rsp_message_size != 8'd0 &&
                                     rsp_status == STATUS_OK))
      else $error("bad mid-stream result");

   // consecutive bytes of one stream share size and room
   a_stream_const: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_last) ##1 !rsp_empty |->
         (rsp_message_size == $past(rsp_message_size) &&
          rsp_room_left == $past(rsp_room_left)))
      else $error("stream changed size or room");

   // total room covers the current buffer
   a_room_order: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_total_room >= 12'(rsp_room_left)))
      else $error("total room below room left");

   // a waiting result stays put until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_last) &&
                                    $stable(rsp_message_size)))
      else $error("waiting result changed");

endmodule

bind tlv_uplink_message_packer_core tlvp_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_last         (rsp_last),
   .rsp_status       (rsp_status),
   .rsp_message_size (rsp_message_size),
   .rsp_room_left    (rsp_room_left),
   .rsp_total_room   (rsp_total_room)
);
